@@ rtl/gmdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared types and constants of the grid maze depth-first search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmdfs_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 2;

   // request codes
   localparam logic [1:0] OP_WRITE_CELL = 2'd0;
   localparam logic [1:0] OP_SEARCH     = 2'd1;
   localparam logic [1:0] OP_READ_PATH  = 2'd2;
   localparam logic [1:0] OP_READ_CELL  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIM       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_ROW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COL = 2'd2;

   localparam logic [4:0] DIM_RESET       = 5'd10;
   localparam logic [3:0] ENTRY_ROW_RESET = 4'd2;
   localparam logic [3:0] ENTRY_COL_RESET = 4'd0;

   // cell codes
   localparam logic [1:0] CELL_OPEN = 2'd0;
   localparam logic [1:0] CELL_WALL = 2'd1;
   localparam logic [1:0] CELL_SEEN = 2'd2;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } dir_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WRITE,
      S_RDCELL,
      S_RDCELL_WAIT,
      S_RDPATH,
      S_RDPATH_WAIT,
      S_START,
      S_VISIT,
      S_PROBE,
      S_CHECK,
      S_POP,
      S_POP_WAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [3:0] row;
      logic [3:0] col;
      logic       ok;
   } nbr_type;

   function automatic dir_type next_dir(input dir_type d);
      dir_type n;
      case (d)
         DIR_UP:   n = DIR_DOWN;
         DIR_DOWN: n = DIR_LEFT;
         DIR_LEFT: n = DIR_RIGHT;
         default:  n = DIR_RIGHT;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/grid_maze_depth_first_search_top.sv @@
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search_top
// Grid maze solver: depth-first walk with an explicit position stack.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (tuser = op), one response per request leaves on
// rsp_*. Registers dim, entry_row and entry_col are written on csr_* at any
// time; change them only while no request is in flight.
// After reset the grid RAM is swept to open, all min(MAZE_DIM,16)^2 cells, with
// req_tready low. Then one request is worked on at a time.
// A search walks from the entry cell, probes the neighbors of each cell in the
// order up, down, left, right and pops the stack to backtrack when none is
// open: every in-grid probe is one registered read of the grid RAM.
// The response sits in an output register; a new request is taken while it
// waits, and a finished request holds until rsp_tready frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_depth_first_search_top #(
   parameter int MAZE_DIM    = 16,
   parameter int STACK_DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // tdata: cell_row[3:0], cell_col[7:4], is_wall[8], path_index[16:9]
   input  wire logic [gmdfs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: op[1:0]
   input  wire logic [1:0]                            req_tuser,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata: found[0], path_length[9:1], out_row[13:10], out_col[17:14],
   //        cell_state[19:18]
   output logic      [gmdfs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [gmdfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [gmdfs_pkg::CSR_DATA_W-1:0]      csr_data
);

   import gmdfs_pkg::*;

   localparam int GRID_SIDE  = (MAZE_DIM < 16) ? MAZE_DIM : 16;
   localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int GAW        = $clog2(GRID_DEPTH);
   localparam int SAW        = $clog2(STACK_DEPTH);
   localparam int SCW        = $clog2(STACK_DEPTH + 1);
   localparam logic [4:0] SIDE_MAX = 5'(GRID_SIDE);

   function automatic logic [GAW-1:0] gaddr(input logic [3:0] r, input logic [3:0] c);
      return GAW'(int'(r) * GRID_SIDE + int'(c));
   endfunction

   function automatic logic in_store(input logic [3:0] r, input logic [3:0] c);
      return (int'(r) < GRID_SIDE) && (int'(c) < GRID_SIDE);
   endfunction

   state_type        state_ff, state_in;
   dir_type          dir_ff, dir_in;
   logic [GAW-1:0]   clear_ff, clear_in;
   logic [3:0]       cur_row_ff, cur_row_in;
   logic [3:0]       cur_col_ff, cur_col_in;
   logic [SCW-1:0]   count_ff, count_in;
   logic             found_ff, found_in;
   logic [3:0]       row_ff, row_in;
   logic [3:0]       col_ff, col_in;
   logic             wall_ff, wall_in;
   logic [7:0]       pidx_ff, pidx_in;
   logic [3:0]       res_row_ff, res_row_in;
   logic [3:0]       res_col_ff, res_col_in;
   logic [1:0]       res_state_ff, res_state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [4:0]       dim_ff;
   logic [3:0]       entry_row_ff;
   logic [3:0]       entry_col_ff;

   logic [4:0]       side;
   logic             path_ok;
   nbr_type          nbr;

   logic             g_wr_en, g_rd_en;
   logic [GAW-1:0]   g_wr_addr, g_rd_addr;
   logic [1:0]       g_wr_data, g_rd_data;
   logic             s_wr_en, s_rd_en;
   logic [SAW-1:0]   s_wr_addr, s_rd_addr;
   logic [7:0]       s_wr_data, s_rd_data;

   always_comb begin
      if (dim_ff > SIDE_MAX) begin
         side = SIDE_MAX;
      end else if (dim_ff < 5'd2) begin
         side = 5'd2;
      end else begin
         side = dim_ff;
      end
   end

   assign path_ok = (32'(pidx_ff) < 32'(count_ff)) && (32'(pidx_ff) < STACK_DEPTH);

   gmdfs_nbr u_nbr (
      .cur_row (cur_row_ff),
      .cur_col (cur_col_ff),
      .dir     (dir_ff),
      .side    (side),
      .nbr     (nbr)
   );

   gmdfs_ram #(.WIDTH(2), .DEPTH(GRID_DEPTH)) u_grid (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (g_rd_en),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   gmdfs_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DIM_RESET;
         entry_row_ff <= ENTRY_ROW_RESET;
         entry_col_ff <= ENTRY_COL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIM:       dim_ff       <= csr_data;
            CSR_ENTRY_ROW: entry_row_ff <= csr_data[3:0];
            CSR_ENTRY_COL: entry_col_ff <= csr_data[3:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff       <= dir_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      wall_ff      <= wall_in;
      pidx_ff      <= pidx_in;
      res_row_ff   <= res_row_in;
      res_col_ff   <= res_col_in;
      res_state_ff <= res_state_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      clear_in     = clear_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wall_in      = wall_ff;
      pidx_in      = pidx_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      res_state_in = res_state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      g_wr_en   = 1'b0;
      g_wr_addr = gaddr(cur_row_ff, cur_col_ff);
      g_wr_data = CELL_SEEN;
      g_rd_en   = 1'b0;
      g_rd_addr = gaddr(nbr.row, nbr.col);
      s_wr_en   = 1'b0;
      s_wr_addr = count_ff[SAW-1:0];
      s_wr_data = {nbr.row, nbr.col};
      s_rd_en   = 1'b0;
      s_rd_addr = SAW'(count_ff - SCW'(2));

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            g_wr_en   = 1'b1;
            g_wr_addr = clear_ff;
            g_wr_data = CELL_OPEN;
            clear_in  = clear_ff + GAW'(1);
            if (clear_ff == GAW'(GRID_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               row_in       = req_tdata[3:0];
               col_in       = req_tdata[7:4];
               wall_in      = req_tdata[8];
               pidx_in      = req_tdata[16:9];
               res_row_in   = 4'd0;
               res_col_in   = 4'd0;
               res_state_in = CELL_OPEN;
               case (req_tuser)
                  OP_WRITE_CELL: state_in = S_WRITE;
                  OP_SEARCH:     state_in = S_START;
                  OP_READ_PATH:  state_in = S_RDPATH;
                  default:       state_in = S_RDCELL;
               endcase
            end
         end
         S_WRITE: begin
            g_wr_en   = in_store(row_ff, col_ff);
            g_wr_addr = gaddr(row_ff, col_ff);
            g_wr_data = wall_ff ? CELL_WALL : CELL_OPEN;
            state_in  = S_OUT;
         end
         S_RDCELL: begin
            g_rd_en   = 1'b1;
            g_rd_addr = gaddr(row_ff, col_ff);
            state_in  = S_RDCELL_WAIT;
         end
         S_RDCELL_WAIT: begin
            res_row_in   = row_ff;
            res_col_in   = col_ff;
            res_state_in = in_store(row_ff, col_ff) ? g_rd_data : CELL_WALL;
            state_in     = S_OUT;
         end
         S_RDPATH: begin
            s_rd_en   = path_ok;
            s_rd_addr = SAW'(pidx_ff);
            state_in  = S_RDPATH_WAIT;
         end
         S_RDPATH_WAIT: begin
            if (path_ok) begin
               res_row_in = s_rd_data[7:4];
               res_col_in = s_rd_data[3:0];
            end
            state_in = S_OUT;
         end
         S_START: begin
            found_in = 1'b0;
            count_in = '0;
            if (({1'b0, entry_row_ff} >= side) || ({1'b0, entry_col_ff} >= side)) begin
               state_in = S_OUT;
            end else begin
               s_wr_en    = 1'b1;
               s_wr_addr  = '0;
               s_wr_data  = {entry_row_ff, entry_col_ff};
               count_in   = SCW'(1);
               cur_row_in = entry_row_ff;
               cur_col_in = entry_col_ff;
               state_in   = S_VISIT;
            end
         end
         S_VISIT: begin
            g_wr_en = 1'b1;
            if ({1'b0, cur_row_ff} == side - 5'd1) begin
               found_in = 1'b1;
               state_in = S_OUT;
            end else begin
               dir_in   = DIR_UP;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (nbr.ok) begin
               g_rd_en  = 1'b1;
               state_in = S_CHECK;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = S_POP;
            end else begin
               dir_in = next_dir(dir_ff);
            end
         end
         S_CHECK: begin
            if (g_rd_data == CELL_OPEN) begin
               if (count_ff >= SCW'(STACK_DEPTH)) begin
                  state_in = S_OUT;
               end else begin
                  s_wr_en    = 1'b1;
                  count_in   = count_ff + SCW'(1);
                  cur_row_in = nbr.row;
                  cur_col_in = nbr.col;
                  state_in   = S_VISIT;
               end
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = S_POP;
            end else begin
               dir_in   = next_dir(dir_ff);
               state_in = S_PROBE;
            end
         end
         S_POP: begin
            count_in = count_ff - SCW'(1);
            if (count_ff == SCW'(1)) begin
               state_in = S_OUT;
            end else begin
               s_rd_en  = 1'b1;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cur_row_in = s_rd_data[7:4];
            cur_col_in = s_rd_data[3:0];
            state_in   = S_VISIT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_state_ff, res_col_ff, res_row_ff,
                                           9'(count_ff), found_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SCW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (count_ff != '0))
      else $error("found with empty stack");

   a_cur_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VISIT) |-> (({1'b0, cur_row_ff} < side) && ({1'b0, cur_col_ff} < side)))
      else $error("current cell outside grid");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside output state");

endmodule

`default_nettype wire

@@ rtl/gmdfs_ram.sv @@
// ----------------------------------------------------------------------------
// gmdfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gmdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/gmdfs_nbr.sv @@
// ----------------------------------------------------------------------------
// gmdfs_nbr
// Neighbor unit: steps one cell in a direction and checks it against the side.
// ----------------------------------------------------------------------------
`default_nettype none

module gmdfs_nbr (
   input  wire logic              [3:0] cur_row,
   input  wire logic              [3:0] cur_col,
   input  wire gmdfs_pkg::dir_type      dir,
   input  wire logic              [4:0] side,
   output gmdfs_pkg::nbr_type           nbr
);

   import gmdfs_pkg::*;

   always_comb begin
      nbr.row = cur_row;
      nbr.col = cur_col;
      nbr.ok  = 1'b0;
      case (dir)
         DIR_UP: begin
            nbr.row = cur_row - 4'd1;
            nbr.ok  = (cur_row != 4'd0);
         end
         DIR_DOWN: begin
            nbr.row = cur_row + 4'd1;
            nbr.ok  = (({1'b0, cur_row} + 5'd1) < side);
         end
         DIR_LEFT: begin
            nbr.col = cur_col - 4'd1;
            nbr.ok  = (cur_col != 4'd0);
         end
         DIR_RIGHT: begin
            nbr.col = cur_col + 4'd1;
            nbr.ok  = (({1'b0, cur_col} + 5'd1) < side);
         end
         default: begin
            nbr.ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire
